// File: rtl/battery_soc_curve_interpolator_assert.svh
// assertion macros shared by the checker of the soc curve interpolator
// no dependencies; included by bsci_checker.sv
`ifndef BATTERY_SOC_CURVE_INTERPOLATOR_ASSERT_SVH
`define BATTERY_SOC_CURVE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define BSCI_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bsci_pkg.sv
// constants, discharge curve roms and controller/datapath types for the
// soc curve interpolator; no dependencies
`default_nettype none

package bsci_pkg;

   localparam int CURVE_COUNT    = 6;
   localparam int VOLTAGE_BITS   = 18;
   localparam int ROM_CURVES     = 6;
   localparam int MAX_POINTS     = 14;
   localparam int REF_MV         = 12000;
   localparam int REF_BITS       = 14;
   localparam int NOMINAL_BITS   = 17;
   localparam int CHEM_BITS      = 3;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 17;
   localparam int MV_BITS        = 15;
   localparam int PCT_BITS       = 7;
   localparam int STEP_BITS      = 4;
   localparam int SPAN_BITS      = 11;
   localparam int NUM_BITS       = 16;
   localparam int IDX_BITS       = $clog2(MAX_POINTS);
   localparam int SEL_BITS       = $clog2(ROM_CURVES);
   localparam int COUNT_BITS     = $clog2(MAX_POINTS + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHEMISTRY = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOMINAL   = CSR_INDEX_BITS'(1);

   localparam logic [CHEM_BITS-1:0]    CHEM_RESET    = CHEM_BITS'(0);
   localparam logic [NOMINAL_BITS-1:0] NOMINAL_RESET = NOMINAL_BITS'(12000);
   localparam logic [PCT_BITS-1:0]     PCT_FULL      = PCT_BITS'(100);

   localparam logic [COUNT_BITS-1:0] CURVE_POINTS [ROM_CURVES] =
      '{4'd11, 4'd11, 4'd11, 4'd12, 4'd14, 4'd11};

   // voltages fall along each row; unused tail points are zero
   localparam logic [MV_BITS-1:0] CURVE_MV [ROM_CURVES][MAX_POINTS] = '{
      '{15'd12700, 15'd12500, 15'd12420, 15'd12320, 15'd12200, 15'd12060, 15'd11900,
        15'd11750, 15'd11580, 15'd11310, 15'd10500, 15'd0,     15'd0,     15'd0},
      '{15'd12800, 15'd12600, 15'd12500, 15'd12350, 15'd12240, 15'd12100, 15'd11960,
        15'd11810, 15'd11660, 15'd11510, 15'd10800, 15'd0,     15'd0,     15'd0},
      '{15'd12850, 15'd12650, 15'd12550, 15'd12400, 15'd12300, 15'd12150, 15'd12000,
        15'd11880, 15'd11750, 15'd11580, 15'd11000, 15'd0,     15'd0,     15'd0},
      '{15'd12600, 15'd12450, 15'd12300, 15'd12150, 15'd12000, 15'd11880, 15'd11760,
        15'd11610, 15'd11460, 15'd11220, 15'd10950, 15'd9000,  15'd0,     15'd0},
      '{15'd14400, 15'd13600, 15'd13450, 15'd13350, 15'd13300, 15'd13280, 15'd13250,
        15'd13220, 15'd13200, 15'd13150, 15'd13000, 15'd12500, 15'd12000, 15'd11000},
      '{15'd14400, 15'd13800, 15'd13200, 15'd12800, 15'd12500, 15'd12300, 15'd12100,
        15'd11900, 15'd11600, 15'd11200, 15'd10000, 15'd0,     15'd0,     15'd0}
   };

   localparam logic [PCT_BITS-1:0] CURVE_PCT [ROM_CURVES][MAX_POINTS] = '{
      '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30,  7'd20, 7'd10, 7'd0,  7'd0,  7'd0,  7'd0},
      '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30,  7'd20, 7'd10, 7'd0,  7'd0,  7'd0,  7'd0},
      '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30,  7'd20, 7'd10, 7'd0,  7'd0,  7'd0,  7'd0},
      '{7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40,  7'd30, 7'd20, 7'd10, 7'd0,  7'd0,  7'd0},
      '{7'd100, 7'd99, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60,
        7'd50,  7'd40, 7'd30, 7'd20, 7'd10, 7'd5,  7'd0},
      '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
        7'd30,  7'd20, 7'd10, 7'd0,  7'd0,  7'd0,  7'd0}
   };

   typedef struct packed {
      logic load;
      logic mul;
      logic div_scale;
      logic div_interp;
      logic v12_load;
      logic idx_clear;
      logic idx_inc;
      logic bracket_load;
      logic set_zero;
      logic set_full;
      logic set_low;
      logic soc_interp;
   } cmd_type;

   typedef struct packed {
      logic nom_zero;
      logic div_done;
      logic above_top;
      logic below_bottom;
      logic bracket_hit;
      logic span_zero;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/bsci_div.sv
// restoring divider, one quotient bit per cycle, run length chosen at start
// depends on nothing outside this file
`default_nettype none

module bsci_div #(
   parameter int DIVIDEND_BITS = 32,
   parameter int DIVISOR_BITS  = 17,
   parameter int ITER_BITS     = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   input  logic [ITER_BITS-1:0]     iters,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic                     done
);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [ITER_BITS-1:0]     cnt_ff, cnt_in;
   logic                     run_ff, run_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         cnt_in     = iters;
         run_in     = 1'b1;
      end else if (run_ff && cnt_ff != '0) begin
         // dividend bits shift out at the top, quotient bits in at the bottom
         rem_in = fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - ITER_BITS'(1);
      end else if (run_ff) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = run_ff && cnt_ff == '0;

endmodule

`default_nettype wire

// File: rtl/bsci_dpath.sv
// datapath: config registers, scaling multiplier, shared divider, curve rom
// lookup and interpolation; depends on bsci_pkg and bsci_div
`default_nettype none

module bsci_dpath #(
   parameter int VOLTAGE_BITS = bsci_pkg::VOLTAGE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [VOLTAGE_BITS-1:0]             req_battery_voltage_mv,
   input  logic                                csr_wr_en,
   input  logic [bsci_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bsci_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  bsci_pkg::cmd_type                   cmd,
   output bsci_pkg::status_type                status,
   output logic [bsci_pkg::PCT_BITS-1:0]       soc_percent
);

   localparam int PROD_BITS = VOLTAGE_BITS + bsci_pkg::REF_BITS;
   localparam int ITER_BITS = $clog2(PROD_BITS + 1);
   localparam int SCALED_BITS = bsci_pkg::SPAN_BITS + bsci_pkg::STEP_BITS;

   logic [bsci_pkg::CHEM_BITS-1:0]    chemistry_ff, chemistry_in;
   logic [bsci_pkg::NOMINAL_BITS-1:0] nominal_ff, nominal_in;
   logic [VOLTAGE_BITS-1:0]           voltage_ff, voltage_in;
   logic [bsci_pkg::SEL_BITS-1:0]     sel_ff, sel_in;
   logic [PROD_BITS-1:0]              prod_ff, prod_in;
   logic [PROD_BITS-1:0]              v12_ff, v12_in;
   logic [bsci_pkg::IDX_BITS-1:0]     idx_ff, idx_in;
   logic [bsci_pkg::SPAN_BITS-1:0]    diff_ff, diff_in;
   logic [bsci_pkg::SPAN_BITS-1:0]    span_ff, span_in;
   logic [bsci_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [bsci_pkg::PCT_BITS-1:0]     low_pct_ff, low_pct_in;
   logic [bsci_pkg::PCT_BITS-1:0]     soc_ff, soc_in;

   logic [bsci_pkg::IDX_BITS-1:0]     last_idx;
   logic [bsci_pkg::IDX_BITS-1:0]     next_idx;
   logic [bsci_pkg::MV_BITS-1:0]      top_mv, bot_mv, hi_mv, lo_mv;
   logic [bsci_pkg::PCT_BITS-1:0]     hi_pct, lo_pct;
   logic [SCALED_BITS-1:0]            scaled;
   logic [bsci_pkg::NUM_BITS-1:0]     numerator;
   logic [PROD_BITS-1:0]              div_dividend;
   logic [bsci_pkg::NOMINAL_BITS-1:0] div_divisor;
   logic [ITER_BITS-1:0]              div_iters;
   logic [PROD_BITS-1:0]              quotient;
   logic                              div_done;
   logic [bsci_pkg::PCT_BITS:0]       interp_sum;

   // configuration writes
   always_comb begin
      chemistry_in = chemistry_ff;
      nominal_in   = nominal_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bsci_pkg::CSR_CHEMISTRY: chemistry_in = csr_wdata[bsci_pkg::CHEM_BITS-1:0];
            bsci_pkg::CSR_NOMINAL:   nominal_in   = csr_wdata[bsci_pkg::NOMINAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chemistry_ff <= bsci_pkg::CHEM_RESET;
         nominal_ff   <= bsci_pkg::NOMINAL_RESET;
      end else begin
         chemistry_ff <= chemistry_in;
         nominal_ff   <= nominal_in;
      end
   end

   // curve rom reads
   assign last_idx = bsci_pkg::IDX_BITS'(bsci_pkg::CURVE_POINTS[sel_ff]
                                         - bsci_pkg::COUNT_BITS'(1));
   assign next_idx = idx_ff + bsci_pkg::IDX_BITS'(1);
   assign top_mv   = bsci_pkg::CURVE_MV[sel_ff][0];
   assign bot_mv   = bsci_pkg::CURVE_MV[sel_ff][last_idx];
   assign hi_mv    = bsci_pkg::CURVE_MV[sel_ff][idx_ff];
   assign lo_mv    = bsci_pkg::CURVE_MV[sel_ff][next_idx];
   assign hi_pct   = bsci_pkg::CURVE_PCT[sel_ff][idx_ff];
   assign lo_pct   = bsci_pkg::CURVE_PCT[sel_ff][next_idx];

   // rounding numerator 2*(v12-vl)*dp + span, divided later by 2*span
   assign scaled    = SCALED_BITS'(diff_ff) * SCALED_BITS'(step_ff);
   assign numerator = bsci_pkg::NUM_BITS'({scaled, 1'b0})
                    + bsci_pkg::NUM_BITS'(span_ff);

   assign div_dividend = cmd.div_interp
                       ? {numerator, {(PROD_BITS - bsci_pkg::NUM_BITS){1'b0}}}
                       : prod_ff;
   assign div_divisor  = cmd.div_interp
                       ? bsci_pkg::NOMINAL_BITS'({span_ff, 1'b0})
                       : nominal_ff;
   assign div_iters    = cmd.div_interp ? ITER_BITS'(bsci_pkg::NUM_BITS)
                                        : ITER_BITS'(PROD_BITS);

   bsci_div #(
      .DIVIDEND_BITS (PROD_BITS),
      .DIVISOR_BITS  (bsci_pkg::NOMINAL_BITS),
      .ITER_BITS     (ITER_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_scale | cmd.div_interp),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .quotient (quotient),
      .done     (div_done)
   );

   assign interp_sum = (bsci_pkg::PCT_BITS + 1)'(low_pct_ff)
                     + (bsci_pkg::PCT_BITS + 1)'(quotient[bsci_pkg::PCT_BITS-1:0]);

   always_comb begin
      voltage_in = voltage_ff;
      sel_in     = sel_ff;
      prod_in    = prod_ff;
      v12_in     = v12_ff;
      idx_in     = idx_ff;
      diff_in    = diff_ff;
      span_in    = span_ff;
      step_in    = step_ff;
      low_pct_in = low_pct_ff;
      soc_in     = soc_ff;
      if (cmd.load) begin
         voltage_in = req_battery_voltage_mv;
         // unknown chemistry falls back to lead-acid
         if (int'(chemistry_ff) >= bsci_pkg::CURVE_COUNT
             || int'(chemistry_ff) >= bsci_pkg::ROM_CURVES) begin
            sel_in = '0;
         end else begin
            sel_in = bsci_pkg::SEL_BITS'(chemistry_ff);
         end
      end
      if (cmd.mul) begin
         prod_in = PROD_BITS'(voltage_ff) * PROD_BITS'(bsci_pkg::REF_MV);
      end
      if (cmd.v12_load) begin
         v12_in = quotient;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = next_idx;
      end
      if (cmd.bracket_load) begin
         span_in    = bsci_pkg::SPAN_BITS'(hi_mv - lo_mv);
         diff_in    = bsci_pkg::SPAN_BITS'(v12_ff - PROD_BITS'(lo_mv));
         step_in    = (hi_pct >= lo_pct) ? bsci_pkg::STEP_BITS'(hi_pct - lo_pct) : '0;
         low_pct_in = lo_pct;
      end
      if (cmd.set_zero) begin
         soc_in = '0;
      end else if (cmd.set_full) begin
         soc_in = bsci_pkg::PCT_FULL;
      end else if (cmd.set_low) begin
         soc_in = low_pct_ff;
      end else if (cmd.soc_interp) begin
         soc_in = (interp_sum > (bsci_pkg::PCT_BITS + 1)'(bsci_pkg::PCT_FULL))
                ? bsci_pkg::PCT_FULL : interp_sum[bsci_pkg::PCT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      voltage_ff <= voltage_in;
      sel_ff     <= sel_in;
      prod_ff    <= prod_in;
      v12_ff     <= v12_in;
      idx_ff     <= idx_in;
      diff_ff    <= diff_in;
      span_ff    <= span_in;
      step_ff    <= step_in;
      low_pct_ff <= low_pct_in;
      soc_ff     <= soc_in;
   end

   always_comb begin
      status.nom_zero     = nominal_ff == '0;
      status.div_done     = div_done;
      status.above_top    = v12_ff >= PROD_BITS'(top_mv);
      status.below_bottom = v12_ff <= PROD_BITS'(bot_mv);
      status.bracket_hit  = v12_ff >= PROD_BITS'(lo_mv);
      status.span_zero    = span_ff == '0;
   end

   assign soc_percent = soc_ff;

endmodule

`default_nettype wire

// File: rtl/bsci_ctrl.sv
// controller state machine sequencing scale, divide, bracket scan and
// interpolation; depends on bsci_pkg
`default_nettype none

module bsci_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bsci_pkg::status_type status,
   output bsci_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL       = 4'd1;
   localparam logic [3:0] S_DIV1_GO   = 4'd2;
   localparam logic [3:0] S_DIV1_WAIT = 4'd3;
   localparam logic [3:0] S_CHECK     = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_INTERP    = 4'd6;
   localparam logic [3:0] S_DIV2_WAIT = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (status.nom_zero) begin
               cmd.set_zero = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIV1_GO;
            end
         end
         S_DIV1_GO: begin
            cmd.div_scale = 1'b1;
            state_in      = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (status.div_done) begin
               cmd.v12_load = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.above_top) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else if (status.below_bottom) begin
               cmd.set_zero = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            // v12 lies strictly inside the curve, so a bracket is always found
            if (status.bracket_hit) begin
               cmd.bracket_load = 1'b1;
               state_in         = S_INTERP;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_INTERP: begin
            if (status.span_zero) begin
               cmd.set_low = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.div_interp = 1'b1;
               state_in       = S_DIV2_WAIT;
            end
         end
         S_DIV2_WAIT: begin
            if (status.div_done) begin
               cmd.soc_interp = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;

endmodule

`default_nettype wire

// File: rtl/battery_soc_curve_interpolator.sv
// top level of the battery soc curve interpolator: controller plus datapath
// depends on bsci_pkg, bsci_ctrl, bsci_dpath
//
// A voltage sample is taken when start is high and busy is low; busy then
// stays high until the result has been shown. The sample is scaled to a 12 V
// equivalent (v12 = floor(v * 12000 / nominal)), looked up in the selected
// discharge curve and linearly interpolated, rounded half up. The result
// appears on rsp_soc_percent for exactly one cycle with rsp_strobe high and
// must be taken then: there is no back-pressure. busy drops in the cycle
// after the strobe. The single restoring divider, one quotient bit a cycle,
// is used first for the scaling and again for the interpolation, and the
// bracket scan steps one point a cycle. chemistry and nominal_voltage_mv
// are to be written through the csr port only while busy is low; the block
// itself does not enforce this.
`default_nettype none

module battery_soc_curve_interpolator #(
   parameter int VOLTAGE_BITS = bsci_pkg::VOLTAGE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [VOLTAGE_BITS-1:0]             req_battery_voltage_mv,
   output logic                                rsp_strobe,
   output logic [bsci_pkg::PCT_BITS-1:0]       rsp_soc_percent,
   input  logic                                csr_wr_en,
   input  logic [bsci_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bsci_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   bsci_pkg::cmd_type    cmd;
   bsci_pkg::status_type status;

   bsci_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   bsci_dpath #(
      .VOLTAGE_BITS (VOLTAGE_BITS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .req_battery_voltage_mv (req_battery_voltage_mv),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .cmd                    (cmd),
      .status                 (status),
      .soc_percent            (rsp_soc_percent)
   );

endmodule

`default_nettype wire

// File: rtl/bsci_checker.sv
// port-level checker for the soc curve interpolator, bound to the top level
// depends on bsci_pkg and battery_soc_curve_interpolator_assert.svh
`default_nettype none

`include "battery_soc_curve_interpolator_assert.svh"

module bsci_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [bsci_pkg::PCT_BITS-1:0] rsp_soc_percent
);

   `BSCI_ASSERT_IMPLIES(a_soc_in_range, clock, reset, rsp_strobe, rsp_soc_percent <= bsci_pkg::PCT_FULL, "soc result above full scale")
   `BSCI_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy, "busy not raised after accepted transaction")
   `BSCI_ASSERT_IMPLIES(a_strobe_while_busy, clock, reset, rsp_strobe, busy, "result strobe with no transaction in flight")
   `BSCI_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe && !busy, "result repeated or busy held after result")
   `BSCI_ASSERT_IMPLIES(a_busy_ends_on_result, clock, reset, !$past(reset) && $fell(busy), $past(rsp_strobe), "transaction ended without a result")

endmodule

bind battery_soc_curve_interpolator bsci_checker u_bsci_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_soc_percent (rsp_soc_percent)
);

`default_nettype wire
